/* hw/rtl/zero_run_length_encoder_top_macros.svh */
// Assertion helpers; clk and arst_n are taken from the enclosing scope.
`ifndef ZERO_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define ZERO_RUN_LENGTH_ENCODER_TOP_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ZRLE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ZRLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/zrle_pkg.sv */
`timescale 1ns / 1ps

package zrle_pkg;

	localparam int SYMBOL_BITS   = 32;
	localparam int SWIDTH_BITS   = 6;
	localparam int WORD_BITS_DEF = 32;
	localparam int OBUF_DEPTH    = 4;
	localparam int OBUF_CNT_BITS = $clog2(OBUF_DEPTH + 1);
	localparam int RES_MAX       = 3;

	localparam logic [SWIDTH_BITS-1:0] SWIDTH_RST = SWIDTH_BITS'(8);
	localparam logic [SYMBOL_BITS-1:0] ZERO_SYM_RST = '0;

	// configuration register indexes
	localparam logic REG_SYMBOL_WIDTH = 1'b0;
	localparam logic REG_ZERO_SYMBOL  = 1'b1;

	// input operations
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic                   op;
		logic [SYMBOL_BITS-1:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [SYMBOL_BITS-1:0] word;
		logic                   last;
	} out_item_t;

	// up to three result words handed from the encoder to the output queue
	typedef struct packed {
		logic [1:0]   num;
		out_item_t [RES_MAX-1:0] res;
	} push_t;

	// Clamp the programmed width to 1..word_bits and build the symbol mask.
	function automatic logic [SYMBOL_BITS-1:0] width_mask(
		input logic [SWIDTH_BITS-1:0] sw,
		input logic [SWIDTH_BITS-1:0] word_bits
	);
		logic [SWIDTH_BITS-1:0] w;
		logic [SYMBOL_BITS:0]   m;
		w = sw;
		if (w == '0) w = SWIDTH_BITS'(1);
		if (w > word_bits) w = word_bits;
		m = ((SYMBOL_BITS+1)'(1) << w) - (SYMBOL_BITS+1)'(1);
		return m[SYMBOL_BITS-1:0];
	endfunction

endpackage

/* hw/rtl/zrle_stage.sv */
`timescale 1ns / 1ps

module zrle_stage #(
	parameter int WORD_BITS = zrle_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  zrle_pkg::in_item_t                  in_item,
	input  logic [zrle_pkg::SYMBOL_BITS-1:0]    mask,
	input  logic [zrle_pkg::SYMBOL_BITS-1:0]    zero_symbol,
	input  logic [zrle_pkg::OBUF_CNT_BITS-1:0]  obuf_free,
	output logic                                push_valid,
	output zrle_pkg::push_t                     push
);
	import zrle_pkg::*;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic [WORD_BITS-1:0]   run_q;
	logic [WORD_BITS-1:0]   run_nxt;
	logic [SYMBOL_BITS-1:0] val;
	logic [SYMBOL_BITS-1:0] run_word;
	logic                   pend;
	logic                   fire;

	assign val      = item_s1.symbol & mask;
	assign run_word = SYMBOL_BITS'(run_q);
	assign pend     = (run_q != '0);

	always_comb begin
		push          = '0;
		run_nxt       = run_q;
		push.res[0].word = zero_symbol;
		push.res[1].word = run_word;
		push.res[2].word = val;
		push.res[2].last = 1'b1;
		if (item_s1.op == OP_FLUSH) begin
			push.num         = pend ? 2'd2 : 2'd0;
			push.res[1].last = 1'b1;
			run_nxt          = '0;
		end else if (val != zero_symbol) begin
			if (pend) begin
				push.num = 2'd3;
			end else begin
				push.num         = 2'd1;
				push.res[0].word = val;
				push.res[0].last = 1'b1;
			end
			run_nxt = '0;
		end else if (run_word >= mask) begin
			// count already at its limit: emit the full pair, restart at one
			push.num         = 2'd2;
			push.res[1].last = 1'b1;
			run_nxt          = WORD_BITS'(1);
		end else begin
			push.num = 2'd0;
			run_nxt  = run_q + WORD_BITS'(1);
		end
	end

	assign fire       = valid_s1 && (OBUF_CNT_BITS'(push.num) <= obuf_free);
	assign push_valid = fire;
	assign in_ready   = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			run_q    <= '0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire) run_q <= run_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_item;
	end

endmodule

/* hw/rtl/zrle_obuf.sv */
`timescale 1ns / 1ps

module zrle_obuf (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push_valid,
	input  zrle_pkg::push_t                    push,
	output logic [zrle_pkg::OBUF_CNT_BITS-1:0] obuf_free,
	output logic                               out_valid,
	input  logic                               out_ready,
	output zrle_pkg::out_item_t                out_item
);
	import zrle_pkg::*;

	out_item_t [OBUF_DEPTH-1:0] q_q;
	out_item_t [OBUF_DEPTH-1:0] q_nxt;
	logic [OBUF_CNT_BITS-1:0]   cnt_q;
	logic [OBUF_CNT_BITS-1:0]   base;
	logic [OBUF_CNT_BITS-1:0]   num;
	logic                       pop;

	assign out_valid = (cnt_q != '0);
	assign out_item  = q_q[0];
	assign obuf_free = OBUF_CNT_BITS'(OBUF_DEPTH) - cnt_q;
	assign pop       = out_valid && out_ready;
	assign base      = cnt_q - OBUF_CNT_BITS'(pop);
	assign num       = push_valid ? OBUF_CNT_BITS'(push.num) : '0;

	// shift out the head on a transaction, then append new words behind the rest
	always_comb begin
		logic [OBUF_CNT_BITS-1:0] k;
		for (int i = 0; i < OBUF_DEPTH; i++) begin
			k = OBUF_CNT_BITS'(i) - base;
			q_nxt[i] = q_q[i];
			if (OBUF_CNT_BITS'(i) < base) begin
				if (pop && i < OBUF_DEPTH - 1) q_nxt[i] = q_q[i+1];
			end else if (k < num) begin
				q_nxt[i] = push.res[k[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + num;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_nxt;
	end

endmodule

/* hw/rtl/zero_run_length_encoder_top.sv */
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// --------+-------------------------+---------------------------------
// in      | in_valid / in_ready     | in_item  (op, symbol)
// out     | out_valid / out_ready   | out_item (word, last)
// cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One input item per cycle enters the input register while in_ready is high; the
// encoder hands its 0 to 3 words from that register to a four-entry output queue once
// the queue has room for them. The queue drains one word per cycle while out_ready is
// high, so plain symbols flow at one item per cycle while the output is ready.
// Input stalls while the queue, counted before this cycle's output transaction, lacks
// room for the held item's words. Reset clears the run count, the queue and the
// configuration (width 8, zero symbol 0).

module zero_run_length_encoder_top #(
	parameter int WORD_BITS = zrle_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  zrle_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output zrle_pkg::out_item_t              out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [zrle_pkg::SYMBOL_BITS-1:0] cfg_data
);
	import zrle_pkg::*;

	logic [SYMBOL_BITS-1:0]   mask_q;
	logic [SYMBOL_BITS-1:0]   zero_sym_q;
	logic [OBUF_CNT_BITS-1:0] obuf_free;
	logic                     push_valid;
	push_t                    push;

	assign cfg_ready = 1'b1;

	// keep the decoded mask rather than the raw width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= width_mask(SWIDTH_RST, SWIDTH_BITS'(WORD_BITS));
			zero_sym_q <= ZERO_SYM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYMBOL_WIDTH: mask_q <= width_mask(cfg_data[SWIDTH_BITS-1:0],
					SWIDTH_BITS'(WORD_BITS));
				REG_ZERO_SYMBOL:  zero_sym_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	zrle_stage #(
		.WORD_BITS(WORD_BITS)
	) u_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.mask       (mask_q),
		.zero_symbol(zero_sym_q),
		.obuf_free  (obuf_free),
		.push_valid (push_valid),
		.push       (push)
	);

	zrle_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push      (push),
		.obuf_free (obuf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* hw/rtl/zrle_chk.sv */
`timescale 1ns / 1ps
`include "zero_run_length_encoder_top_macros.svh"

module zrle_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input zrle_pkg::out_item_t out_item,
	input logic                cfg_ready
);

	// a stalled result holds its word
	`ZRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "output changed while stalled")

	// input backpressure only comes from words waiting at the output
	`ZRLE_ASSERT_IMPL(a_stall_has_out, !in_ready, out_valid, "input stalled with empty output")

	// output valid drops only after a transaction
	`ZRLE_ASSERT_IMPL(a_out_drop, $fell(out_valid), $past(out_ready), "output dropped without transaction")

	// configuration writes are never refused
	`ZRLE_ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind zero_run_length_encoder_top zrle_chk u_chk (.*);
